// ----- rtl/core/square_matrix_multiply_core_defines.svh -----
// ----------------------------------------------------------------------------
// Square matrix multiply core: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SQUARE_MATRIX_MULTIPLY_CORE_DEFINES_SVH
`define SQUARE_MATRIX_MULTIPLY_CORE_DEFINES_SVH

// Same-cycle implication.
`define SMM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/smm_pkg.sv -----
// ----------------------------------------------------------------------------
// smm_pkg
// Types and constants shared by the square matrix multiply core.
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

  localparam int IDX_W       = 3;   // row / column index width
  localparam int VAL_W       = 32;  // Q16.16 element width
  localparam int DIM_W       = 4;   // dimension register width
  localparam int FRAC_W      = 16;  // fraction bits
  localparam int PROD_W      = 2 * VAL_W;
  localparam int ACC_W       = 68;  // exact sum of up to 8 products
  localparam int MAX_DIM_DEF = 8;
  localparam int QUEUE_DEPTH = 2;

  // Request as classified by the front end
  typedef struct packed {
    logic             wr;    // indices in range: store the pair
    logic             done;  // final load: start a product run
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } smm_req_t;

  // Tag that travels with each multiply-accumulate step
  typedef struct packed {
    logic             first;  // first term of a dot product
    logic             last;   // last term of a dot product
    logic             fin;    // last term of the last element of the run
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } smm_tag_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } smm_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/square_matrix_multiply_core.sv -----
// ----------------------------------------------------------------------------
// Square matrix multiply core
// Loads two square Q16.16 matrices element by element and streams A * B.
// ----------------------------------------------------------------------------
// Each request (start high while busy is low) stores one element of A and one
// of B at (in_row_index, in_col_index); indices at or beyond MAX_DIM store
// nothing. A request with in_load_done set stores its pair and then starts a
// product run over the configured dimension n (cfg_dimension; 0 acts as 1,
// above MAX_DIM acts as MAX_DIM; the user must write it only while the core
// is idle, as the core does not enforce it). The run emits all n*n elements
// in row-major order, one per out_strobe pulse, with out_last_element on the
// final one. There is no backpressure: the receiver must take every strobed
// result. Each element is the exact dot product, floor-shifted by 16 bits and
// saturated to signed 32 bits. Unloaded elements in use give undefined
// results.
// Rate: requests enter a two-deep queue at one per cycle while busy is low,
// and the store side takes one per cycle while idle. A run occupies the
// single multiply-accumulate unit, issuing one term per cycle; the last
// element appears once its final term has passed the read, multiply,
// accumulate and output registers. During a run the queue holds arriving
// requests; once it is full, busy stays high until the run has issued its
// last term and the sequencer, back in idle, has taken the queue head.
// ----------------------------------------------------------------------------
`default_nettype none

module square_matrix_multiply_core #(
  parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [smm_pkg::DIM_W-1:0]        cfg_dimension,
  // load requests
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [smm_pkg::IDX_W-1:0]        in_row_index,
  input  wire logic [smm_pkg::IDX_W-1:0]        in_col_index,
  input  wire logic signed [smm_pkg::VAL_W-1:0] in_a_value,
  input  wire logic signed [smm_pkg::VAL_W-1:0] in_b_value,
  input  wire logic                             in_load_done,
  // product elements
  output logic                                  out_strobe,
  output logic [smm_pkg::IDX_W-1:0]             out_row,
  output logic [smm_pkg::IDX_W-1:0]             out_col,
  output logic signed [smm_pkg::VAL_W-1:0]      out_product_value,
  output logic                                  out_last_element
);

  // queue head handed from front end to back end
  logic              q_valid;
  logic              q_pop;
  smm_pkg::smm_req_t q_head;

  smm_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_a_value   (in_a_value),
    .in_b_value   (in_b_value),
    .in_load_done (in_load_done),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop)
  );

  // back end owns the stores, the run sequencer and the MAC pipeline
  smm_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_dimension     (cfg_dimension),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_strobe        (out_strobe),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_product_value (out_product_value),
    .out_last_element  (out_last_element)
  );

endmodule

`default_nettype wire

// ----- rtl/core/smm_front.sv -----
// ----------------------------------------------------------------------------
// smm_front
// Accepts load requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_front #(
  parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [smm_pkg::IDX_W-1:0]     in_row_index,
  input  wire logic [smm_pkg::IDX_W-1:0]     in_col_index,
  input  wire logic signed [smm_pkg::VAL_W-1:0] in_a_value,
  input  wire logic signed [smm_pkg::VAL_W-1:0] in_b_value,
  input  wire logic                          in_load_done,
  output logic                               q_valid,
  output smm_pkg::smm_req_t                  q_head,
  input  wire logic                          q_pop
);

  localparam int DEPTH = smm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  smm_pkg::smm_req_t entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  smm_pkg::smm_req_t req;
  logic              push;
  logic              pop;

  always_comb begin
    req.wr   = (int'(in_row_index) < MAX_DIM) && (int'(in_col_index) < MAX_DIM);
    req.done = in_load_done;
    req.row  = in_row_index;
    req.col  = in_col_index;
    req.a    = in_a_value;
    req.b    = in_b_value;
  end

  assign busy    = (count_r == CNT_W'(DEPTH));
  assign push    = start && !busy;
  assign q_valid = (count_r != '0);
  assign pop     = q_pop && q_valid;
  assign q_head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= req;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/smm_back.sv -----
// ----------------------------------------------------------------------------
// smm_back
// Element stores, run sequencer and the shared multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_back #(
  parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [smm_pkg::DIM_W-1:0]     cfg_dimension,
  input  wire logic                          q_valid,
  input  wire smm_pkg::smm_req_t             q_head,
  output logic                               q_pop,
  output logic                               out_strobe,
  output logic [smm_pkg::IDX_W-1:0]          out_row,
  output logic [smm_pkg::IDX_W-1:0]          out_col,
  output logic signed [smm_pkg::VAL_W-1:0]   out_product_value,
  output logic                               out_last_element
);

  localparam int IDX_W  = smm_pkg::IDX_W;
  localparam int VAL_W  = smm_pkg::VAL_W;
  localparam int DIM_W  = smm_pkg::DIM_W;
  localparam int PROD_W = smm_pkg::PROD_W;
  localparam int ACC_W  = smm_pkg::ACC_W;
  localparam int SH_W   = ACC_W - smm_pkg::FRAC_W;
  localparam int CELLS  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  // Config register and effective dimension minus one
  logic [DIM_W-1:0] dim_r;
  logic [IDX_W-1:0] dim_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_W'(MAX_DIM);
    end else if (cfg_we) begin
      dim_r <= cfg_dimension;
    end
  end

  always_comb begin
    if (dim_r == '0) begin
      dim_m1 = '0;
    end else if (int'(dim_r) > MAX_DIM) begin
      dim_m1 = IDX_W'(MAX_DIM - 1);
    end else begin
      dim_m1 = IDX_W'(dim_r - 1'b1);
    end
  end

  // Sequencer
  smm_pkg::smm_state_t state_r, state_nxt;
  logic [IDX_W-1:0]    n_m1_r, n_m1_nxt;
  logic [IDX_W-1:0]    r_r, r_nxt, c_r, c_nxt, k_r, k_nxt;
  logic                issue;
  logic                wr_en;
  smm_pkg::smm_tag_t   tag0;

  always_comb begin
    state_nxt = state_r;
    n_m1_nxt  = n_m1_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    q_pop     = 1'b0;
    issue     = 1'b0;
    wr_en     = 1'b0;
    case (state_r)
      smm_pkg::ST_IDLE: begin
        q_pop = q_valid;
        wr_en = q_valid && q_head.wr;
        if (q_valid && q_head.done) begin
          state_nxt = smm_pkg::ST_RUN;
          n_m1_nxt  = dim_m1;
          r_nxt     = '0;
          c_nxt     = '0;
          k_nxt     = '0;
        end
      end
      smm_pkg::ST_RUN: begin
        issue = 1'b1;
        if (k_r == n_m1_r) begin
          k_nxt = '0;
          if (c_r == n_m1_r) begin
            c_nxt = '0;
            if (r_r == n_m1_r) begin
              state_nxt = smm_pkg::ST_IDLE;
            end else begin
              r_nxt = r_r + 1'b1;
            end
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: begin
        state_nxt = smm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    tag0.first = (k_r == '0);
    tag0.last  = (k_r == n_m1_r);
    tag0.fin   = (k_r == n_m1_r) && (c_r == n_m1_r) && (r_r == n_m1_r);
    tag0.row   = r_r;
    tag0.col   = c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smm_pkg::ST_IDLE;
      n_m1_r  <= '0;
      r_r     <= '0;
      c_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      n_m1_r  <= n_m1_nxt;
      r_r     <= r_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
    end
  end

  // Element stores, row-major at row * MAX_DIM + col
  logic [VAL_W-1:0]  left_mem  [CELLS];
  logic [VAL_W-1:0]  right_mem [CELLS];
  logic [ADDR_W-1:0] wr_addr, a_addr, b_addr;
  logic [VAL_W-1:0]  a_rd_r, b_rd_r;

  assign wr_addr = ADDR_W'(int'(q_head.row) * MAX_DIM + int'(q_head.col));
  assign a_addr  = ADDR_W'(int'(r_r) * MAX_DIM + int'(k_r));
  assign b_addr  = ADDR_W'(int'(k_r) * MAX_DIM + int'(c_r));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_mem[wr_addr]  <= q_head.a;
      right_mem[wr_addr] <= q_head.b;
    end
    if (issue) begin
      a_rd_r <= left_mem[a_addr];
      b_rd_r <= right_mem[b_addr];
    end
  end

  // MAC pipeline: read -> multiply -> accumulate -> shift/saturate
  logic                      v1_r, v2_r, v3_r;
  smm_pkg::smm_tag_t         tag1_r, tag2_r, tag3_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [SH_W-1:0]    shifted;
  logic [VAL_W-1:0]          sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign prod_ext = ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    tag1_r <= tag0;
    tag2_r <= tag1_r;
    tag3_r <= tag2_r;
    prod_r <= $signed(a_rd_r) * $signed(b_rd_r);
    if (v2_r) begin
      acc_r <= tag2_r.first ? prod_ext : acc_r + prod_ext;
    end
  end

  // Floor shift, then clamp to the Q16.16 range
  always_comb begin
    shifted = SH_W'(acc_r >>> smm_pkg::FRAC_W);
    if (shifted[SH_W-1:VAL_W-1] == '0 || shifted[SH_W-1:VAL_W-1] == '1) begin
      sat = shifted[VAL_W-1:0];
    end else if (shifted[SH_W-1]) begin
      sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  logic                 strobe_r;
  logic [IDX_W-1:0]     row_r, col_r;
  logic [VAL_W-1:0]     value_r;
  logic                 last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= v3_r && tag3_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r && tag3_r.last) begin
      row_r   <= tag3_r.row;
      col_r   <= tag3_r.col;
      value_r <= sat;
      last_r  <= tag3_r.fin;
    end
  end

  assign out_strobe        = strobe_r;
  assign out_row           = row_r;
  assign out_col           = col_r;
  assign out_product_value = $signed(value_r);
  assign out_last_element  = strobe_r && last_r;

endmodule

`default_nettype wire

// ----- rtl/core/smm_checker.sv -----
// ----------------------------------------------------------------------------
// smm_checker
// Port-level checks on the square matrix multiply core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "square_matrix_multiply_core_defines.svh"

module smm_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      out_strobe,
  input wire logic [smm_pkg::IDX_W-1:0] out_row,
  input wire logic [smm_pkg::IDX_W-1:0] out_col,
  input wire logic                      out_last_element
);

  // final flag only on a strobed element
  `SMM_ASSERT_NOW(a_last_strobed, clk, rst_n, out_last_element, out_strobe, "last without strobe")

  // final element sits on the diagonal
  `SMM_ASSERT_NOW(a_last_diag, clk, rst_n, out_strobe && out_last_element, out_row == out_col, "last element off diagonal")

  // with n >= 2 no strobe directly follows a non-final element
  `SMM_ASSERT_NEXT(a_elem_gap, clk, rst_n, out_strobe && !out_last_element, !out_strobe, "elements too close")

  // queue only fills after a taken request
  `SMM_ASSERT_NOW(a_busy_cause, clk, rst_n, $rose(busy), $past(start), "busy without request")

endmodule

bind square_matrix_multiply_core smm_checker u_smm_checker (.*);

`default_nettype wire
